/* rtl/core/tcc_pkg.sv */
package tcc_pkg;

    // datapath word width for operands and arithmetic
    localparam int WORD_BITS = 32;
    localparam int VALUE_W   = 32;
    localparam int CNT_W     = $clog2(WORD_BITS);

    localparam logic [CNT_W-1:0] DIV_LAST_STEP = CNT_W'(WORD_BITS - 1);

    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_NINE    = 8'd57;

    localparam logic [31:0] KW_EXIT = 32'h4558_4954;
    localparam logic [31:0] KW_ADD  = 32'h0041_4444;
    localparam logic [31:0] KW_SUB  = 32'h0053_5542;
    localparam logic [31:0] KW_MUL  = 32'h004D_554C;
    localparam logic [31:0] KW_DIV  = 32'h0044_4956;

    localparam logic [2:0] KW_LEN_CMD  = 3'd3;
    localparam logic [2:0] KW_LEN_EXIT = 3'd4;
    localparam logic [2:0] KW_LEN_MAX  = 3'd5;

    localparam logic [3:0] COUNT_MAX    = 4'd15;
    localparam logic [3:0] OPERAND_PAIR = 4'd2;

    typedef enum logic [2:0] {
        STS_OK,
        STS_EXIT,
        STS_EMPTY,
        STS_BAD_CMD,
        STS_COUNT,
        STS_BAD_OPERAND,
        STS_DIV_ZERO
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic take_byte;
        logic end_line;
        logic start_div;
        logic div_step;
        logic div_done;
        logic out_take;
    } dp_cmd_t;

    typedef struct packed {
        logic halted;
        logic is_newline;
        logic needs_div;
        logic div_last;
        logic out_full;
    } dp_sts_t;

endpackage

/* rtl/core/tcc_datapath.sv */
module tcc_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  tcc_pkg::dp_cmd_t cmd,
    input  logic [7:0]       char_code,
    output tcc_pkg::dp_sts_t sts,
    output logic [2:0]       status,
    output logic signed [31:0] value,
    output logic [3:0]       operand_count
);
    import tcc_pkg::*;

    // line state
    logic [31:0]          kw_chars_reg, kw_chars_next;
    logic [2:0]           kw_len_reg, kw_len_next;
    logic [3:0]           wc_reg, wc_next;
    logic                 inside_reg, inside_next;
    logic [WORD_BITS-1:0] op_a_reg, op_a_next;
    logic [WORD_BITS-1:0] op_b_reg, op_b_next;
    logic [1:0]           bad_reg, bad_next;
    logic                 halted_reg, halted_next;

    // divider
    logic [WORD_BITS-1:0] dv_quo_reg, dv_quo_next;
    logic [WORD_BITS-1:0] dv_rem_reg, dv_rem_next;
    logic [WORD_BITS-1:0] dv_den_reg, dv_den_next;
    logic                 dv_neg_reg, dv_neg_next;
    logic [CNT_W-1:0]     dv_cnt_reg, dv_cnt_next;

    // result word
    logic                 out_full_reg, out_full_next;
    status_t              out_status_reg, out_status_next;
    logic signed [VALUE_W-1:0] out_value_reg, out_value_next;
    logic [3:0]           out_count_reg, out_count_next;

    logic [3:0]           wc_eff;
    logic                 is_digit;
    logic [WORD_BITS-1:0] digit;
    logic [WORD_BITS-1:0] acc_src;
    logic [WORD_BITS-1:0] acc_new;
    logic                 is_arith;
    status_t              line_status;
    logic [WORD_BITS-1:0] arith_res;
    logic [2*WORD_BITS-1:0] product;
    logic [WORD_BITS:0]   rem_sh;
    logic [WORD_BITS:0]   rem_diff;
    logic [WORD_BITS-1:0] quo_signed;

    assign wc_eff = (!inside_reg && kw_len_reg != '0 && wc_reg < COUNT_MAX)
                    ? wc_reg + 4'd1 : wc_reg;

    // decimal accumulate: acc * 10 + digit, built from shifts
    assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign digit    = WORD_BITS'(char_code - CH_ZERO);
    assign acc_src  = (wc_eff == 4'd1) ? op_a_reg : op_b_reg;
    assign acc_new  = (acc_src << 3) + (acc_src << 1) + digit;

    assign product = op_a_reg * op_b_reg;

    assign is_arith = (kw_len_reg == KW_LEN_CMD)
                      && (kw_chars_reg == KW_ADD || kw_chars_reg == KW_SUB
                          || kw_chars_reg == KW_MUL || kw_chars_reg == KW_DIV);

    always_comb
    begin
        line_status = STS_OK;
        arith_res   = '0;
        if (kw_len_reg == '0)
            line_status = STS_EMPTY;
        else if (kw_len_reg == KW_LEN_EXIT && kw_chars_reg == KW_EXIT)
            line_status = STS_EXIT;
        else if (is_arith)
        begin
            if (wc_reg != OPERAND_PAIR)
                line_status = STS_COUNT;
            else if (bad_reg != '0)
                line_status = STS_BAD_OPERAND;
            else if (kw_chars_reg == KW_ADD)
                arith_res = op_a_reg + op_b_reg;
            else if (kw_chars_reg == KW_SUB)
                arith_res = op_a_reg - op_b_reg;
            else if (kw_chars_reg == KW_MUL)
                arith_res = product[WORD_BITS-1:0];
            else if (op_b_reg == '0)
                line_status = STS_DIV_ZERO;
        end
        else
            line_status = STS_BAD_CMD;
    end

    // restoring division, one quotient bit per step
    assign rem_sh     = {dv_rem_reg, dv_quo_reg[WORD_BITS-1]};
    assign rem_diff   = rem_sh - {1'b0, dv_den_reg};
    assign quo_signed = dv_neg_reg ? ('0 - dv_quo_reg) : dv_quo_reg;

    always_comb
    begin
        kw_chars_next = kw_chars_reg;
        kw_len_next   = kw_len_reg;
        wc_next       = wc_reg;
        inside_next   = inside_reg;
        op_a_next     = op_a_reg;
        op_b_next     = op_b_reg;
        bad_next      = bad_reg;
        halted_next   = halted_reg;

        if (cmd.take_byte)
        begin
            if (char_code == CH_SPACE)
                inside_next = 1'b0;
            else
            begin
                inside_next = 1'b1;
                wc_next     = wc_eff;
                if (wc_eff == '0)
                begin
                    if (kw_len_reg < KW_LEN_EXIT)
                        kw_chars_next = {kw_chars_reg[23:0], char_code};
                    if (kw_len_reg < KW_LEN_MAX)
                        kw_len_next = kw_len_reg + 3'd1;
                end
                else if (wc_eff == 4'd1)
                begin
                    if (is_digit)
                        op_a_next = acc_new;
                    else
                        bad_next[0] = 1'b1;
                end
                else if (wc_eff == OPERAND_PAIR)
                begin
                    if (is_digit)
                        op_b_next = acc_new;
                    else
                        bad_next[1] = 1'b1;
                end
            end
        end

        if (cmd.end_line || cmd.start_div)
        begin
            kw_chars_next = '0;
            kw_len_next   = '0;
            wc_next       = '0;
            inside_next   = 1'b0;
            op_a_next     = '0;
            op_b_next     = '0;
            bad_next      = '0;
        end

        if (cmd.end_line && line_status != STS_OK)
            halted_next = 1'b1;
    end

    always_comb
    begin
        dv_quo_next = dv_quo_reg;
        dv_rem_next = dv_rem_reg;
        dv_den_next = dv_den_reg;
        dv_neg_next = dv_neg_reg;
        dv_cnt_next = dv_cnt_reg;
        if (cmd.start_div)
        begin
            dv_quo_next = op_a_reg[WORD_BITS-1] ? ('0 - op_a_reg) : op_a_reg;
            dv_den_next = op_b_reg[WORD_BITS-1] ? ('0 - op_b_reg) : op_b_reg;
            dv_neg_next = op_a_reg[WORD_BITS-1] ^ op_b_reg[WORD_BITS-1];
            dv_rem_next = '0;
            dv_cnt_next = '0;
        end
        else if (cmd.div_step)
        begin
            dv_rem_next = rem_diff[WORD_BITS] ? rem_sh[WORD_BITS-1:0]
                                              : rem_diff[WORD_BITS-1:0];
            dv_quo_next = {dv_quo_reg[WORD_BITS-2:0], ~rem_diff[WORD_BITS]};
            dv_cnt_next = dv_cnt_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        out_full_next   = out_full_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;
        if (cmd.out_take)
            out_full_next = 1'b0;
        if (cmd.end_line)
        begin
            out_full_next   = 1'b1;
            out_status_next = line_status;
            out_value_next  = (line_status == STS_OK)
                              ? VALUE_W'(signed'(arith_res)) : '0;
            out_count_next  = wc_reg;
        end
        else if (cmd.div_done)
        begin
            out_full_next   = 1'b1;
            out_status_next = STS_OK;
            out_value_next  = VALUE_W'(signed'(quo_signed));
            out_count_next  = OPERAND_PAIR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kw_chars_reg <= '0;
            kw_len_reg   <= '0;
            wc_reg       <= '0;
            inside_reg   <= 1'b0;
            op_a_reg     <= '0;
            op_b_reg     <= '0;
            bad_reg      <= '0;
            halted_reg   <= 1'b0;
            out_full_reg <= 1'b0;
            dv_cnt_reg   <= '0;
        end
        else
        begin
            kw_chars_reg <= kw_chars_next;
            kw_len_reg   <= kw_len_next;
            wc_reg       <= wc_next;
            inside_reg   <= inside_next;
            op_a_reg     <= op_a_next;
            op_b_reg     <= op_b_next;
            bad_reg      <= bad_next;
            halted_reg   <= halted_next;
            out_full_reg <= out_full_next;
            dv_cnt_reg   <= dv_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dv_quo_reg     <= dv_quo_next;
        dv_rem_reg     <= dv_rem_next;
        dv_den_reg     <= dv_den_next;
        dv_neg_reg     <= dv_neg_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
    end

    assign sts.halted     = halted_reg;
    assign sts.is_newline = (char_code == CH_NEWLINE);
    assign sts.needs_div  = is_arith && (kw_chars_reg == KW_DIV) && (wc_reg == OPERAND_PAIR)
                            && (bad_reg == '0) && (op_b_reg != '0);
    assign sts.div_last   = (dv_cnt_reg == DIV_LAST_STEP);
    assign sts.out_full   = out_full_reg;

    assign status        = out_status_reg;
    assign value         = out_value_reg;
    assign operand_count = out_count_reg;

endmodule

/* rtl/core/tcc_ctrl.sv */
module tcc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             out_ready,
    input  tcc_pkg::dp_sts_t sts,
    output tcc_pkg::dp_cmd_t cmd
);
    import tcc_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_free;
    logic        accept;
    logic        line_end;

    assign out_free = !sts.out_full || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign accept   = in_valid && in_ready;
    assign line_end = accept && !sts.halted && sts.is_newline;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (line_end && sts.needs_div)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (sts.div_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.take_byte = accept && !sts.halted && !sts.is_newline;
        cmd.end_line  = line_end && !sts.needs_div;
        cmd.start_div = line_end && sts.needs_div;
        cmd.div_step  = (state_reg == ST_DIV);
        cmd.div_done  = (state_reg == ST_DONE) && out_free;
        cmd.out_take  = sts.out_full && out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // a division start enters the divide state; no byte is taken until it completes
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_div |=> state_reg == ST_DIV)
        else $error("division start did not enter divide state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !sts.out_full) |=> sts.out_full)
        else $error("quotient not loaded into result register");

    assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(sts.halted))
        else $error("halt cleared without reset");

    assert property (@(posedge clk) disable iff (!rst_n)
        (sts.out_full && !out_ready) |-> !in_ready)
        else $error("byte taken while result word is stalled");

endmodule

/* rtl/core/text_command_calculator.sv */
// Text command calculator: takes a command line one byte per word on the char_code
// channel (space separates words, line feed ends the line) and answers each line end
// with one result word holding status, value and operand_count. The first word must be
// EXIT, ADD, SUB, MUL or DIV; arithmetic commands need exactly two unsigned decimal
// operands, parsed modulo 2^32. Status codes: 0 ok, 1 exit, 2 empty line, 3 bad command,
// 4 operand count, 5 bad operand, 6 divide by zero; value is zero unless status is ok.
// After EXIT or any error the block swallows all further bytes without a result until
// reset. Timing: ordinary bytes and non-divide line ends are taken at one per cycle
// unless a full result register stalls them; a DIV line end occupies the block after
// the byte is taken for the 32 steps of the bit-serial restoring divider and the load
// of the result register, during which in_ready stays low. A finished result waiting
// in the result register holds off every input byte until the receiver takes it.

module text_command_calculator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         char_code,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic signed [31:0] value,
    output logic [3:0]         operand_count
);
    import tcc_pkg::*;

    // command and status between sequencer and datapath
    dp_cmd_t cmd;
    dp_sts_t sts;

    tcc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // line parsing, arithmetic, divider and the result register
    tcc_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .char_code     (char_code),
        .sts           (sts),
        .status        (status),
        .value         (value),
        .operand_count (operand_count)
    );

    // result word is valid while the result register is full
    assign out_valid = sts.out_full;

endmodule

/* bench/tb_text_command_calculator.sv */
`timescale 1ns / 1ps

module tb_text_command_calculator;
    import tcc_pkg::*;

    // run shape
    localparam int RANDOM_BYTES   = 1400;
    localparam int LONG_HOLD      = 300;   // receiver hold-off that backs the block up
    localparam int DRAIN_CYCLES   = 60;    // drain time after the last line, long enough for a full divide
    localparam int WATCHDOG_LIMIT = 4000;  // quiet cycles before the run is declared hung
    localparam int HALTED_BYTES   = 40;

    // how the run closes: one halting line, then bytes the block must swallow
    typedef enum int {
        END_EMPTY,
        END_EXIT,
        END_BAD_WORD,
        END_COUNT,
        END_BAD_DIGIT,
        END_DIV_ZERO
    } finale_t;

    // running model of the calculator plus the queue of answers it owes
    class calc_scoreboard;
        typedef struct {
            status_t            st;
            logic signed [31:0] val;
            logic [3:0]         cnt;
        } calc_answer_t;

        calc_answer_t pending_answers[$];
        int           mismatches;
        int           answers_checked;

        logic [31:0] kw_chars;
        logic [2:0]  kw_len;
        logic [3:0]  words;
        bit          in_word;
        logic [31:0] opnd_a;
        logic [31:0] opnd_b;
        logic [1:0]  bad_digits;
        bit          halted;

        function new();
            mismatches      = 0;
            answers_checked = 0;
            halted          = 1'b0;
            clear_line();
        endfunction

        function void clear_line();
            kw_chars   = '0;
            kw_len     = '0;
            words      = '0;
            in_word    = 1'b0;
            opnd_a     = '0;
            opnd_b     = '0;
            bad_digits = '0;
        endfunction

        function logic [31:0] add_digit(logic [31:0] acc, logic [7:0] c, int slot);
            if (c < CH_ZERO || c > CH_NINE)
            begin
                bad_digits[slot] = 1'b1;
                return acc;
            end
            return acc * 32'd10 + 32'(c - CH_ZERO);
        endfunction

        // one accepted input word
        function void note_byte(logic [7:0] c);
            calc_answer_t ans;
            status_t      st;
            logic [31:0]  result;
            logic [31:0]  mag_a;
            logic [31:0]  mag_b;
            logic [31:0]  quot;

            if (halted)
                return;
            if (c == CH_SPACE)
            begin
                in_word = 1'b0;
                return;
            end
            if (c != CH_NEWLINE)
            begin
                if (!in_word)
                begin
                    in_word = 1'b1;
                    if (kw_len != 0 && words < COUNT_MAX)
                        words++;
                end
                if (words == 0)
                begin
                    if (kw_len < KW_LEN_EXIT)
                        kw_chars = {kw_chars[23:0], c};
                    if (kw_len < KW_LEN_MAX)
                        kw_len++;
                end
                else if (words == 1)
                    opnd_a = add_digit(opnd_a, c, 0);
                else if (words == OPERAND_PAIR)
                    opnd_b = add_digit(opnd_b, c, 1);
                return;
            end

            // line end
            st     = STS_OK;
            result = '0;
            if (kw_len == 0)
                st = STS_EMPTY;
            else if (kw_len == KW_LEN_EXIT && kw_chars == KW_EXIT)
                st = STS_EXIT;
            else if (kw_len == KW_LEN_CMD && (kw_chars == KW_ADD || kw_chars == KW_SUB ||
                                              kw_chars == KW_MUL || kw_chars == KW_DIV))
            begin
                if (words != OPERAND_PAIR)
                    st = STS_COUNT;
                else if (bad_digits != 0)
                    st = STS_BAD_OPERAND;
                else if (kw_chars == KW_ADD)
                    result = opnd_a + opnd_b;
                else if (kw_chars == KW_SUB)
                    result = opnd_a - opnd_b;
                else if (kw_chars == KW_MUL)
                    result = opnd_a * opnd_b;
                else if (opnd_b == 0)
                    st = STS_DIV_ZERO;
                else
                begin
                    // divide magnitudes, then fix the sign: truncates toward zero
                    mag_a  = opnd_a[31] ? -opnd_a : opnd_a;
                    mag_b  = opnd_b[31] ? -opnd_b : opnd_b;
                    quot   = mag_a / mag_b;
                    result = (opnd_a[31] != opnd_b[31]) ? -quot : quot;
                end
            end
            else
                st = STS_BAD_CMD;

            ans.st  = st;
            ans.val = (st == STS_OK) ? result : '0;
            ans.cnt = words;
            pending_answers = {pending_answers, ans};
            clear_line();
            if (st != STS_OK)
                halted = 1'b1;
        endfunction

        // one accepted result word against the oldest expectation
        function void check_answer(status_t st, logic signed [31:0] v, logic [3:0] cnt);
            calc_answer_t exp;
            if (pending_answers.size() == 0)
            begin
                $display("%0t: unexpected result: status %0d value %0d count %0d",
                         $time, st, v, cnt);
                mismatches++;
                return;
            end
            exp = pending_answers.pop_front();
            answers_checked++;
            if (st !== exp.st)
            begin
                $display("%0t: status: expected %0d actual %0d", $time, exp.st, st);
                mismatches++;
            end
            if (v !== exp.val)
            begin
                $display("%0t: value: expected %0d actual %0d", $time, exp.val, v);
                mismatches++;
            end
            if (cnt !== exp.cnt)
            begin
                $display("%0t: operand_count: expected %0d actual %0d", $time, exp.cnt, cnt);
                mismatches++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         char_code;
    logic               out_valid;
    logic               out_ready;
    logic [2:0]         status;
    logic signed [31:0] value;
    logic [3:0]         operand_count;

    calc_scoreboard sb;
    logic [7:0]     line_bytes[$];   // text of the line being built
    int             bytes_taken = 0;
    bit             gaps_on;         // sender may idle between words
    bit             stalls_on;       // receiver may stall
    bit             hold_long;       // request for one long receiver hold-off

    text_command_calculator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_code    (char_code),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .value        (value),
        .operand_count(operand_count)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // sample both channels at the rising edge, before the block updates
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            sb.note_byte(char_code);
            bytes_taken++;
        end
        if (rst_n && out_valid && out_ready)
            sb.check_answer(status_t'(status), value, operand_count);
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin : receiver
        int burst;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_long)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_long = 1'b0;
                out_ready <= 1'b1;
            end
            else if (stalls_on && $urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(1, 6);
                out_ready <= 1'b0;
                repeat (burst - 1) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog: too long with no word moving on either channel
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: watchdog fired after %0d quiet cycles", $time, quiet);
        $display("end of test: mismatches");
        $finish;
    end

    // offer one word; returns once it has been taken
    task send_byte(input logic [7:0] c);
        int gap;
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid  <= 1'b0;
                char_code <= 8'($urandom);
            end
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        char_code <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task send_line();
        foreach (line_bytes[i])
            send_byte(line_bytes[i]);
        line_bytes.delete();
    endtask

    // sender stops and waits for every owed result
    task wait_for_answers();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending_answers.size() != 0)
            @(posedge clk);
    endtask

    // add one byte to the end of the line being built
    function void append_byte(logic [7:0] c);
        line_bytes = {line_bytes, c};
    endfunction

    function void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            append_byte(s[i]);
    endfunction

    function void put_spaces(int n);
        repeat (n) append_byte(CH_SPACE);
    endfunction

    // command word bytes, earliest byte in the high lane
    function void put_keyword(logic [31:0] kw, int len);
        for (int i = len - 1; i >= 0; i--)
            append_byte(kw[8*i +: 8]);
    endfunction

    function logic [31:0] pick_arith();
        case ($urandom_range(0, 3))
            0:       return KW_ADD;
            1:       return KW_SUB;
            2:       return KW_MUL;
            default: return KW_DIV;
        endcase
    endfunction

    // decimal operand text: small, full range, extremes, overlong (wraps), zero padded
    function string random_operand();
        int          mode;
        logic [31:0] v;
        string       s;
        mode = $urandom_range(0, 9);
        if (mode <= 3)
            s = $sformatf("%0d", $urandom_range(0, 999));
        else if (mode <= 6)
        begin
            v = $urandom;
            s = $sformatf("%0d", v);
        end
        else if (mode == 7)
        begin
            case ($urandom_range(0, 4))
                0:       s = "0";
                1:       s = "1";
                2:       s = "2147483647";
                3:       s = "2147483648";
                default: s = "4294967295";
            endcase
        end
        else if (mode == 8)
        begin
            s = "";
            repeat ($urandom_range(11, 16))
                s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        end
        else
            s = {"000", $sformatf("%0d", $urandom_range(0, 99))};
        return s;
    endfunction

    // a well-formed arithmetic line with random spacing; divisor kept nonzero
    task send_ok_line();
        logic [31:0] kw;
        logic [31:0] divisor;
        string       a;
        string       b;
        kw = pick_arith();
        a  = random_operand();
        do
        begin
            b       = random_operand();
            divisor = '0;
            for (int i = 0; i < b.len(); i++)
                divisor = divisor * 32'd10 + 32'(b[i] - CH_ZERO);
        end
        while (kw == KW_DIV && divisor == 0);
        put_spaces($urandom_range(0, 2));
        put_keyword(kw, KW_LEN_CMD);
        put_spaces($urandom_range(1, 3));
        put_text(a);
        put_spaces($urandom_range(1, 3));
        put_text(b);
        put_spaces($urandom_range(0, 2));
        append_byte(CH_NEWLINE);
        send_line();
    endtask

    initial
    begin : main_flow
        int          line_idx;
        int          n;
        finale_t     finale;
        logic [7:0]  junk;
        logic [31:0] kw;

        sb        = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        char_code = '0;
        out_ready = 1'b0;
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        hold_long = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // directed: wrap at the top, negative results, most negative over minus one,
        // signed truncation, overlong operand, zero padding and loose spacing
        put_text("ADD 4294967295 1\n");
        put_text("SUB 0 1\n");
        put_text("MUL 65536 65537\n");
        put_text("DIV 2147483648 4294967295\n");
        put_text("DIV 4294967289 2\n");
        put_text("  ADD  4294967296   007 \n");
        send_line();
        wait_for_answers();

        // random well-formed lines; idling mostly on, off near the end
        line_idx = 0;
        while (bytes_taken < RANDOM_BYTES)
        begin
            if (bytes_taken > RANDOM_BYTES * 3 / 4)
            begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            else
            begin
                gaps_on   = ($urandom_range(0, 3) != 0);
                stalls_on = ($urandom_range(0, 3) != 0);
            end
            if (line_idx == 6)
            begin
                // receiver holds off while short lines keep coming, so the result
                // register fills and the next line end must wait
                hold_long = 1'b1;
                repeat (4)
                begin
                    put_text("MUL 3 5\n");
                    send_line();
                end
            end
            send_ok_line();
            if (line_idx % 16 == 15)
                wait_for_answers();
            line_idx++;
        end
        wait_for_answers();

        // one halting line chosen at random
        finale = finale_t'($urandom_range(0, 5));
        case (finale)
            END_EMPTY:
                put_spaces($urandom_range(0, 3));
            END_EXIT:
            begin
                put_keyword(KW_EXIT, KW_LEN_EXIT);
                repeat ($urandom_range(0, 3))
                begin
                    put_spaces(1);
                    put_text(random_operand());
                end
            end
            END_BAD_WORD:
            begin
                case ($urandom_range(0, 5))
                    0: put_text("add");
                    1: put_text("EXITS");
                    2: put_text("AD");
                    3: put_text("ADDD");
                    4: put_text("DIVIDE");
                    default:
                        repeat ($urandom_range(1, 6))
                        begin
                            do junk = 8'($urandom_range(0, 255));
                            while (junk == CH_SPACE || junk == CH_NEWLINE);
                            append_byte(junk);
                        end
                endcase
                put_text(" 1 2");
            end
            END_COUNT:
            begin
                // any count but two, up past the saturation point
                n = $urandom_range(0, 19);
                if (n >= 2)
                    n++;
                put_keyword(pick_arith(), KW_LEN_CMD);
                repeat (n)
                begin
                    put_spaces($urandom_range(1, 2));
                    put_text(random_operand());
                end
            end
            END_BAD_DIGIT:
            begin
                do junk = 8'($urandom_range(0, 255));
                while (junk == CH_SPACE || junk == CH_NEWLINE ||
                       (junk >= CH_ZERO && junk <= CH_NINE));
                n = $urandom_range(0, 1);
                put_keyword(pick_arith(), KW_LEN_CMD);
                put_spaces(1);
                put_text(random_operand());
                if (n == 0)
                    append_byte(junk);
                put_spaces(1);
                if (n == 1)
                    append_byte(junk);
                put_text(random_operand());
            end
            default:
            begin
                put_text("DIV ");
                put_text(random_operand());
                put_text(($urandom_range(0, 1) == 0) ? " 0" : " 4294967296");
            end
        endcase
        append_byte(CH_NEWLINE);
        send_line();

        // the halted block must swallow everything, line ends included
        append_byte(8'h00);
        append_byte(8'hFF);
        repeat (HALTED_BYTES)
            append_byte(8'($urandom_range(0, 255)));
        kw = pick_arith();
        put_keyword(kw, KW_LEN_CMD);
        put_text(" 1 2\n");
        send_line();
        wait_for_answers();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d results over %0d input words, all four operations",
                 sb.answers_checked, bytes_taken);
        $display("closed on a %s line, then fed the halted block", finale.name());
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
